### rtl/core/kwmc_pkg.sv
// Shared constants for the k-way merge chunker.
package kwmc_pkg;

  localparam int STREAM_W   = 4;
  localparam int LOC_W      = 64;
  localparam int CNT_BITS   = 21;
  localparam int STREAMS_W  = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 21;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CHUNK_LEN = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_STREAMS   = 1'b1;

  // input actions
  localparam logic ACT_KEY     = 1'b0;
  localparam logic ACT_EXHAUST = 1'b1;

  typedef logic [CNT_BITS-1:0] cnt_t;

endpackage

### rtl/core/kway_merge_chunker.sv
// Top level of the k-way merge chunker: stream bookkeeping, min scan, chunk counter.
// An item that leaves no stream awaiting a key starts the min scan, and the result is
//   loaded into the output register in the result state; other items update bookkeeping.
// The input stalls outside the idle state: no item is taken while the min scan reads the
//   key memory one entry per cycle; one beat may wait in the output register meanwhile.
// Reset (synchronous, rst_n low): chunk length 1, 16 streams in use, all heads invalid,
//   every stream in use awaiting its key, chunk counter zero. No clearing pass.
module kway_merge_chunker #(
  parameter int MAX_STREAMS = 16,
  parameter int KEY_BITS    = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [kwmc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [kwmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [kwmc_pkg::STREAM_W-1:0]     in_stream,
  input  logic signed [kwmc_pkg::LOC_W-1:0] in_location,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_has_record,
  output logic [kwmc_pkg::STREAM_W-1:0]     out_chosen_stream,
  output logic signed [kwmc_pkg::LOC_W-1:0] out_chosen_location,
  output logic [kwmc_pkg::CNT_BITS-1:0]     out_chunk_count,
  output logic                              out_chunk_end,
  output logic                              out_merge_done
);

  import kwmc_pkg::*;

  localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CNT_W = $clog2(MAX_STREAMS + 1);
  localparam int CMP_W = (CNT_W > STREAM_W) ? CNT_W : STREAM_W;

  // control states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  // streams_in_use clamped into 1..MAX_STREAMS
  function automatic logic [CNT_W-1:0] clamp_n(input logic [STREAMS_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > MAX_STREAMS) begin
      r = CNT_W'(MAX_STREAMS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  logic [1:0]             state_r;
  cnt_t                   chunk_len_r;
  logic [CNT_W-1:0]       live_n_r;
  logic [MAX_STREAMS-1:0] head_valid_r;
  logic [MAX_STREAMS-1:0] awaiting_r;
  logic [CNT_W-1:0]       await_cnt_r;
  cnt_t                   rec_r;
  logic                   finished_r;

  // scan pipeline
  logic [IDX_W-1:0]       scan_idx_r;
  logic                   scan_issue_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   best_found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [KEY_BITS-1:0]    best_key_r;

  // output register
  logic                   out_valid_r;
  logic                   out_has_record_r;
  logic [STREAM_W-1:0]    out_chosen_stream_r;
  logic signed [LOC_W-1:0] out_chosen_location_r;
  cnt_t                   out_chunk_count_r;
  logic                   out_chunk_end_r;
  logic                   out_merge_done_r;

  logic [KEY_BITS-1:0]    mem_q;
  logic                   in_acc;
  logic [CMP_W-1:0]       stream_ext;
  logic [IDX_W-1:0]       sidx;
  logic                   item_ok;
  logic                   key_we;
  logic [CNT_W-1:0]       await_cnt_nxt;
  logic                   slot_free;
  logic                   take_best;
  cnt_t                   limit;
  cnt_t                   rec_nxt;
  logic [MAX_STREAMS-1:0] awaiting_init;

  // only the idle state takes beats
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign stream_ext = CMP_W'(in_stream);
  assign sidx       = IDX_W'(stream_ext);
  assign item_ok    = !finished_r && (stream_ext < CMP_W'(live_n_r)) && awaiting_r[sidx];
  assign key_we     = in_acc && item_ok && (in_action == ACT_KEY);
  assign await_cnt_nxt = await_cnt_r - CNT_W'(1);

  // result slot is free when empty or drained this cycle
  assign slot_free  = !out_valid_r || !out_stall;

  // strict less keeps the lowest index on ties (scan runs upward)
  assign take_best  = cmp_vld_r && head_valid_r[cmp_idx_r] &&
                      (!best_found_r || ($signed(mem_q) < $signed(best_key_r)));

  assign limit      = (chunk_len_r == '0) ? cnt_t'(1) : chunk_len_r;
  assign rec_nxt    = rec_r + cnt_t'(1);

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      awaiting_init[i] = (i < int'(clamp_n(cfg_wdata[STREAMS_W-1:0])));
    end
  end

  kwmc_key_mem #(
    .DEPTH (MAX_STREAMS),
    .WIDTH (KEY_BITS)
  ) u_key_mem (
    .clk   (clk),
    .we    (key_we),
    .waddr (sidx),
    .wdata (in_location[KEY_BITS-1:0]),
    .raddr (scan_idx_r),
    .rdata (mem_q)
  );

  // control and bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chunk_len_r  <= cnt_t'(1);
      live_n_r     <= clamp_n(STREAMS_W'(16));
      head_valid_r <= '0;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        awaiting_r[i] <= (i < int'(clamp_n(STREAMS_W'(16))));
      end
      await_cnt_r  <= clamp_n(STREAMS_W'(16));
      rec_r        <= '0;
      finished_r   <= 1'b0;
      scan_issue_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // result beat is loaded from the result state, dropped once taken
      if ((state_r == ST_RESULT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we && (cfg_addr == REG_CHUNK_LEN)) begin
        chunk_len_r <= cfg_wdata;
      end

      if (cfg_we && (cfg_addr == REG_STREAMS)) begin
        // new stream count restarts the merge
        live_n_r     <= clamp_n(cfg_wdata[STREAMS_W-1:0]);
        head_valid_r <= '0;
        awaiting_r   <= awaiting_init;
        await_cnt_r  <= clamp_n(cfg_wdata[STREAMS_W-1:0]);
        rec_r        <= '0;
        finished_r   <= 1'b0;
        state_r      <= ST_IDLE;
        scan_issue_r <= 1'b0;
        cmp_vld_r    <= 1'b0;
      end else begin
        case (state_r)
          ST_IDLE: begin
            if (in_acc && item_ok) begin
              head_valid_r[sidx] <= (in_action == ACT_KEY);
              awaiting_r[sidx]   <= 1'b0;
              await_cnt_r        <= await_cnt_nxt;
              if (await_cnt_nxt == '0) begin
                state_r      <= ST_SCAN;
                scan_issue_r <= 1'b1;
                best_found_r <= 1'b0;
              end
            end
          end
          ST_SCAN: begin
            cmp_vld_r <= scan_issue_r;
            if (scan_issue_r && (CNT_W'(scan_idx_r) == live_n_r - CNT_W'(1))) begin
              scan_issue_r <= 1'b0;
            end
            if (take_best) begin
              best_found_r <= 1'b1;
            end
            if (!scan_issue_r && !cmp_vld_r) begin
              state_r <= ST_RESULT;
            end
          end
          ST_RESULT: begin
            if (slot_free) begin
              state_r <= ST_IDLE;
              if (best_found_r) begin
                awaiting_r[best_idx_r] <= 1'b1;
                await_cnt_r            <= CNT_W'(1);
                rec_r <= (rec_nxt >= limit) ? '0 : rec_nxt;
              end else begin
                // every stream exhausted: end of merge
                rec_r      <= '0;
                finished_r <= 1'b1;
              end
            end
          end
          default: begin
            state_r <= ST_IDLE;
          end
        endcase
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      scan_idx_r <= '0;
    end else if (scan_issue_r) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (take_best) begin
      best_idx_r <= cmp_idx_r;
      best_key_r <= mem_q;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if ((state_r == ST_RESULT) && slot_free) begin
      out_has_record_r <= best_found_r;
      out_merge_done_r <= !best_found_r;
      if (best_found_r) begin
        out_chosen_stream_r   <= STREAM_W'(best_idx_r);
        out_chosen_location_r <= LOC_W'($signed(best_key_r));
        out_chunk_count_r     <= rec_nxt;
        out_chunk_end_r       <= (rec_nxt >= limit);
      end else begin
        out_chosen_stream_r   <= '0;
        out_chosen_location_r <= '0;
        out_chunk_count_r     <= rec_r;
        out_chunk_end_r       <= (rec_r != '0);
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_has_record      = out_has_record_r;
  assign out_chosen_stream   = out_chosen_stream_r;
  assign out_chosen_location = out_chosen_location_r;
  assign out_chunk_count     = out_chunk_count_r;
  assign out_chunk_end       = out_chunk_end_r;
  assign out_merge_done      = out_merge_done_r;

  // awaiting counter tracks the awaiting flags
  a_await_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    int'(await_cnt_r) == $countones(awaiting_r))
    else $error("awaiting count out of step with flags");

  // a scan only runs once no stream awaits a key
  a_scan_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (await_cnt_r == '0) && !finished_r)
    else $error("scan started with streams still awaiting");

  // an end-of-merge beat is only sent once the merge is marked finished
  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_merge_done_r) |-> finished_r && !out_has_record_r)
    else $error("merge done beat without finished state");

endmodule

### rtl/core/kwmc_key_mem.sv
// Head key store: one write port, one read port, registered read data.
module kwmc_key_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
